FILE: design/gpst_pkg.sv
`timescale 1ns / 1ps
// Package for the generational process slot table.
// Shared types, codes and controller/datapath interface structs. No dependencies.
package gpst_pkg;

    localparam int SLOTS_DEFAULT = 64;
    localparam int CFG_W         = 7;
    localparam int CFG_RESET     = 64;
    localparam logic [31:0] GEN_SAT = 32'hffff_ffff;

    localparam logic [2:0] REQ_CREATE    = 3'd0;
    localparam logic [2:0] REQ_CREATE_AT = 3'd1;
    localparam logic [2:0] REQ_EXIT      = 3'd2;
    localparam logic [2:0] REQ_FAULT     = 3'd3;
    localparam logic [2:0] REQ_SNAPSHOT  = 3'd4;
    localparam logic [2:0] REQ_OBSERVE   = 3'd5;
    localparam logic [2:0] REQ_REAP      = 3'd6;
    localparam logic [2:0] REQ_FIND      = 3'd7;

    localparam logic [1:0] PS_EMPTY = 2'd0;
    localparam logic [1:0] PS_RUN   = 2'd1;
    localparam logic [1:0] PS_EXIT  = 2'd2;
    localparam logic [1:0] PS_FAULT = 2'd3;

    localparam logic [1:0] TK_NONE  = 2'd0;
    localparam logic [1:0] TK_EXIT  = 2'd1;
    localparam logic [1:0] TK_FAULT = 2'd2;

    typedef enum logic [3:0] {
        STS_OK       = 4'd0,
        STS_ARG      = 4'd1,
        STS_STATE    = 4'd2,
        STS_GEN      = 4'd3,
        STS_STALE    = 4'd4,
        STS_DUP      = 4'd5,
        STS_CAP      = 4'd6,
        STS_PERM     = 4'd7,
        STS_PEND     = 4'd8,
        STS_NOTFOUND = 4'd9
    } status_t;

    typedef enum logic [1:0] {
        SEL_TGT  = 2'd0,
        SEL_PAR  = 2'd1,
        SEL_IDX  = 2'd2,
        SEL_SCAN = 2'd3
    } addr_sel_t;

    typedef enum logic [2:0] {
        WR_NONE  = 3'd0,
        WR_CLEAR = 3'd1,
        WR_PLACE = 3'd2,
        WR_EXIT  = 3'd3,
        WR_FAULT = 3'd4,
        WR_REAP  = 3'd5
    } wr_op_t;

    typedef enum logic [1:0] {
        FK_NONE  = 2'd0,
        FK_PLACE = 2'd1,
        FK_SNAP  = 2'd2,
        FK_FIND  = 2'd3
    } fin_kind_t;

    typedef struct packed {
        logic [1:0]  state;
        logic [31:0] gen;
        logic [31:0] id;
        logic [63:0] parent;
        logic [1:0]  kind;
        logic [31:0] exit_code;
        logic [31:0] fvec;
        logic [31:0] ferr;
        logic [63:0] faddr;
    } slot_t;

    typedef struct packed {
        logic      cfg_we;
        logic      req_load;
        logic      rd_en;
        addr_sel_t rd_sel;
        logic      hold_load;
        logic      place_from_rd;
        logic      place_from_free;
        logic      scan_start;
        logic      ctr_inc;
        wr_op_t    wr_op;
        logic      fin;
        status_t   fin_status;
        fin_kind_t fin_kind;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [2:0] req_type;
        logic       n_zero;
        logic       id_zero;
        logic       idx_bad;
        logic       tgt_wf;
        logic       oth_wf;
        logic       oth_zero;
        logic       rd_live;
        logic [1:0] rd_state;
        logic       rd_gen_sat;
        logic       rd_par_eq;
        logic       ctr_at_n;
        logic       ctr_at_slots;
        logic       scan_pend;
        logic       dup;
        logic       free;
        logic       child;
        logic       found;
        logic       out_free;
    } dp_stat_t;

endpackage

FILE: design/generational_process_slot_table.sv
`timescale 1ns / 1ps
// Top level of the generational process slot table.
// Depends on gpst_pkg, gpst_ctrl, gpst_dp (which holds gpst_ram).

// After reset the block sweeps every slot of its RAM to zero and takes
// no request (in_stall high, cfg_ready low) until the sweep ends. One request is
// worked at a time through a slot RAM with one write port and a registered read.
// Create, find_runnable and reap read every slot in use, one a cycle;
// create_at adds one more read for its slot before the scan. Exit, fault,
// snapshot and observe read only the target slot, and no slot when the handle
// is malformed. A finished result sits in an output register, so the next
// request is taken while it waits. slots_in_use is written only while idle.
module generational_process_slot_table #(
    parameter int SLOTS = gpst_pkg::SLOTS_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [gpst_pkg::CFG_W-1:0] cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [2:0]                 req_type,
    input  logic [5:0]                 slot_index,
    input  logic [31:0]                proc_id,
    input  logic [63:0]                target_handle,
    input  logic [63:0]                other_handle,
    input  logic signed [31:0]         exit_code,
    input  logic [31:0]                fault_vector_in,
    input  logic [31:0]                fault_error_in,
    input  logic [63:0]                fault_address_in,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [3:0]                 status,
    output logic [63:0]                result_handle,
    output logic [31:0]                result_id,
    output logic [63:0]                result_parent,
    output logic [1:0]                 result_state,
    output logic [1:0]                 result_kind,
    output logic signed [31:0]         result_exit_code,
    output logic [31:0]                result_fault_vector,
    output logic [31:0]                result_fault_error,
    output logic [63:0]                result_fault_address
);

    gpst_pkg::ctrl_cmd_t cmd;
    gpst_pkg::dp_stat_t  st;

    gpst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .st        (st),
        .cmd       (cmd)
    );

    gpst_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cmd                  (cmd),
        .st                   (st),
        .cfg_data             (cfg_data),
        .req_type             (req_type),
        .slot_index           (slot_index),
        .proc_id              (proc_id),
        .target_handle        (target_handle),
        .other_handle         (other_handle),
        .exit_code            (exit_code),
        .fault_vector_in      (fault_vector_in),
        .fault_error_in       (fault_error_in),
        .fault_address_in     (fault_address_in),
        .out_valid            (out_valid),
        .out_stall            (out_stall),
        .status               (status),
        .result_handle        (result_handle),
        .result_id            (result_id),
        .result_parent        (result_parent),
        .result_state         (result_state),
        .result_kind          (result_kind),
        .result_exit_code     (result_exit_code),
        .result_fault_vector  (result_fault_vector),
        .result_fault_error   (result_fault_error),
        .result_fault_address (result_fault_address)
    );

endmodule

FILE: design/gpst_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gpst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/gpst_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the slot table: steps each request through reads, scan and write.
// Depends on gpst_pkg.
module gpst_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  gpst_pkg::dp_stat_t st,
    output gpst_pkg::ctrl_cmd_t cmd
);

    typedef enum logic [8:0] {
        S_CLEAR    = 9'b000000001,
        S_IDLE     = 9'b000000010,
        S_DISPATCH = 9'b000000100,
        S_AT_EVAL  = 9'b000001000,
        S_PAR_EVAL = 9'b000010000,
        S_TGT_EVAL = 9'b000100000,
        S_SCAN     = 9'b001000000,
        S_WRITE    = 9'b010000000,
        S_FIN      = 9'b100000000
    } state_t;

    state_t              state_reg, state_next;
    gpst_pkg::status_t   fin_status_reg, fin_status_next;
    gpst_pkg::fin_kind_t fin_kind_reg, fin_kind_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            fin_status_reg <= gpst_pkg::STS_OK;
            fin_kind_reg   <= gpst_pkg::FK_NONE;
        end
        else
        begin
            state_reg      <= state_next;
            fin_status_reg <= fin_status_next;
            fin_kind_reg   <= fin_kind_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        fin_status_next = fin_status_reg;
        fin_kind_next   = fin_kind_reg;
        cmd             = '0;
        cmd.fin_status  = fin_status_reg;
        cmd.fin_kind    = fin_kind_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                if (st.ctr_at_slots)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.wr_op   = gpst_pkg::WR_CLEAR;
                    cmd.ctr_inc = 1'b1;
                end
            end
            S_IDLE:
            begin
                cmd.cfg_we = cfg_valid;
                if (in_valid)
                begin
                    cmd.req_load = 1'b1;
                    state_next   = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                fin_kind_next = gpst_pkg::FK_NONE;
                if (st.n_zero)
                begin
                    fin_status_next = gpst_pkg::STS_ARG;
                    state_next      = S_FIN;
                end
                else if (st.req_type == gpst_pkg::REQ_CREATE ||
                         st.req_type == gpst_pkg::REQ_FIND)
                begin
                    if (st.id_zero)
                    begin
                        fin_status_next = gpst_pkg::STS_ARG;
                        state_next      = S_FIN;
                    end
                    else
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = S_SCAN;
                    end
                end
                else if (st.req_type == gpst_pkg::REQ_CREATE_AT)
                begin
                    if (st.id_zero || st.idx_bad)
                    begin
                        fin_status_next = gpst_pkg::STS_ARG;
                        state_next      = S_FIN;
                    end
                    else
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = gpst_pkg::SEL_IDX;
                        state_next = S_AT_EVAL;
                    end
                end
                else if (!st.tgt_wf)
                begin
                    fin_status_next = gpst_pkg::STS_ARG;
                    state_next      = S_FIN;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = gpst_pkg::SEL_TGT;
                    state_next = S_TGT_EVAL;
                end
            end
            S_AT_EVAL:
            begin
                if (st.rd_state != gpst_pkg::PS_EMPTY)
                begin
                    fin_status_next = gpst_pkg::STS_STATE;
                    state_next      = S_FIN;
                end
                else if (st.rd_gen_sat)
                begin
                    fin_status_next = gpst_pkg::STS_GEN;
                    state_next      = S_FIN;
                end
                else
                begin
                    cmd.place_from_rd = 1'b1;
                    if (st.oth_zero)
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = S_SCAN;
                    end
                    else if (!st.oth_wf)
                    begin
                        fin_status_next = gpst_pkg::STS_STALE;
                        state_next      = S_FIN;
                    end
                    else
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = gpst_pkg::SEL_PAR;
                        state_next = S_PAR_EVAL;
                    end
                end
            end
            S_PAR_EVAL:
            begin
                if (!st.rd_live)
                begin
                    fin_status_next = gpst_pkg::STS_STALE;
                    state_next      = S_FIN;
                end
                else if (st.rd_state != gpst_pkg::PS_RUN)
                begin
                    fin_status_next = gpst_pkg::STS_STATE;
                    state_next      = S_FIN;
                end
                else if (st.req_type == gpst_pkg::REQ_CREATE_AT)
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
                else
                begin
                    state_next = S_WRITE;
                end
            end
            S_TGT_EVAL:
            begin
                cmd.hold_load = 1'b1;
                if (!st.rd_live)
                begin
                    fin_status_next = gpst_pkg::STS_STALE;
                    state_next      = S_FIN;
                end
                else if (st.req_type == gpst_pkg::REQ_SNAPSHOT)
                begin
                    fin_status_next = gpst_pkg::STS_OK;
                    fin_kind_next   = gpst_pkg::FK_SNAP;
                    state_next      = S_FIN;
                end
                else if (st.req_type == gpst_pkg::REQ_EXIT ||
                         st.req_type == gpst_pkg::REQ_FAULT)
                begin
                    if (st.rd_state != gpst_pkg::PS_RUN)
                    begin
                        fin_status_next = gpst_pkg::STS_STATE;
                        state_next      = S_FIN;
                    end
                    else
                    begin
                        state_next = S_WRITE;
                    end
                end
                else if (!st.rd_par_eq)
                begin
                    fin_status_next = gpst_pkg::STS_PERM;
                    state_next      = S_FIN;
                end
                else if (st.rd_state == gpst_pkg::PS_RUN)
                begin
                    fin_status_next = gpst_pkg::STS_PEND;
                    state_next      = S_FIN;
                end
                else if (st.req_type == gpst_pkg::REQ_OBSERVE)
                begin
                    fin_status_next = gpst_pkg::STS_OK;
                    fin_kind_next   = gpst_pkg::FK_SNAP;
                    state_next      = S_FIN;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (!st.ctr_at_n)
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_sel  = gpst_pkg::SEL_SCAN;
                    cmd.ctr_inc = 1'b1;
                end
                else if (!st.scan_pend)
                begin
                    state_next = S_FIN;
                    if (st.req_type == gpst_pkg::REQ_FIND)
                    begin
                        fin_status_next = st.found ? gpst_pkg::STS_OK
                                                   : gpst_pkg::STS_NOTFOUND;
                        fin_kind_next   = gpst_pkg::FK_FIND;
                    end
                    else if (st.req_type == gpst_pkg::REQ_REAP)
                    begin
                        if (st.child)
                        begin
                            fin_status_next = gpst_pkg::STS_STATE;
                        end
                        else
                        begin
                            state_next = S_WRITE;
                        end
                    end
                    else if (st.dup)
                    begin
                        fin_status_next = gpst_pkg::STS_DUP;
                    end
                    else if (st.req_type == gpst_pkg::REQ_CREATE_AT)
                    begin
                        state_next = S_WRITE;
                    end
                    else if (!st.free)
                    begin
                        fin_status_next = gpst_pkg::STS_CAP;
                    end
                    else
                    begin
                        cmd.place_from_free = 1'b1;
                        if (st.oth_zero)
                        begin
                            state_next = S_WRITE;
                        end
                        else if (!st.oth_wf)
                        begin
                            fin_status_next = gpst_pkg::STS_STALE;
                        end
                        else
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = gpst_pkg::SEL_PAR;
                            state_next = S_PAR_EVAL;
                        end
                    end
                end
            end
            S_WRITE:
            begin
                fin_status_next = gpst_pkg::STS_OK;
                fin_kind_next   = gpst_pkg::FK_NONE;
                state_next      = S_FIN;
                if (st.req_type == gpst_pkg::REQ_CREATE ||
                    st.req_type == gpst_pkg::REQ_CREATE_AT)
                begin
                    cmd.wr_op     = gpst_pkg::WR_PLACE;
                    fin_kind_next = gpst_pkg::FK_PLACE;
                end
                else if (st.req_type == gpst_pkg::REQ_EXIT)
                begin
                    cmd.wr_op = gpst_pkg::WR_EXIT;
                end
                else if (st.req_type == gpst_pkg::REQ_FAULT)
                begin
                    cmd.wr_op = gpst_pkg::WR_FAULT;
                end
                else
                begin
                    cmd.wr_op = gpst_pkg::WR_REAP;
                end
            end
            S_FIN:
            begin
                if (st.out_free)
                begin
                    cmd.fin    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: design/gpst_dp.sv
`timescale 1ns / 1ps
// Datapath of the slot table: request and count registers, slot RAM, scan
// trackers, write formatting and result register. Depends on gpst_pkg, gpst_ram.
module gpst_dp #(
    parameter int SLOTS = gpst_pkg::SLOTS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  gpst_pkg::ctrl_cmd_t          cmd,
    output gpst_pkg::dp_stat_t           st,
    input  logic [gpst_pkg::CFG_W-1:0]   cfg_data,
    input  logic [2:0]                   req_type,
    input  logic [5:0]                   slot_index,
    input  logic [31:0]                  proc_id,
    input  logic [63:0]                  target_handle,
    input  logic [63:0]                  other_handle,
    input  logic signed [31:0]           exit_code,
    input  logic [31:0]                  fault_vector_in,
    input  logic [31:0]                  fault_error_in,
    input  logic [63:0]                  fault_address_in,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [3:0]                   status,
    output logic [63:0]                  result_handle,
    output logic [31:0]                  result_id,
    output logic [63:0]                  result_parent,
    output logic [1:0]                   result_state,
    output logic [1:0]                   result_kind,
    output logic signed [31:0]           result_exit_code,
    output logic [31:0]                  result_fault_vector,
    output logic [31:0]                  result_fault_error,
    output logic [63:0]                  result_fault_address
);

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int SW = $bits(gpst_pkg::slot_t);

    logic [gpst_pkg::CFG_W-1:0] cfg_reg;
    logic [2:0]  req_type_reg;
    logic [5:0]  req_idx_reg;
    logic [31:0] req_id_reg;
    logic [63:0] req_tgt_reg;
    logic [63:0] req_oth_reg;
    logic [31:0] req_exit_reg;
    logic [31:0] req_fvec_reg;
    logic [31:0] req_ferr_reg;
    logic [63:0] req_faddr_reg;

    logic [CW-1:0] ctr_reg;
    logic          scan_vld_reg;
    gpst_pkg::addr_sel_t rd_sel_reg;
    logic [AW-1:0] rd_addr_reg;

    gpst_pkg::slot_t hold_reg;
    logic [AW-1:0]   hold_idx_reg;
    logic [AW-1:0]   place_idx_reg;
    logic [31:0]     place_gen_reg;

    logic            dup_reg, free_reg, child_reg, found_reg;
    logic [AW-1:0]   free_idx_reg, find_idx_reg;
    logic [31:0]     free_gen_reg, find_gen_reg;

    logic            out_vld_reg;
    logic [3:0]      status_reg;
    logic [63:0]     handle_reg;
    gpst_pkg::slot_t snap_reg;

    logic [31:0]     n32;
    logic [CW-1:0]   n;
    logic [AW-1:0]   rd_addr;
    logic [AW-1:0]   wr_addr;
    gpst_pkg::slot_t wr_data;
    gpst_pkg::slot_t rd_data;
    logic [SW-1:0]   rd_bits;
    logic            wr_en;
    logic [31:0]     exp_gen;
    logic [31:0]     place_gen_inc;

    assign n32 = (32'(cfg_reg) > 32'(SLOTS)) ? 32'(SLOTS) : 32'(cfg_reg);
    assign n   = CW'(n32);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg      <= gpst_pkg::CFG_W'(gpst_pkg::CFG_RESET);
            ctr_reg      <= '0;
            scan_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.cfg_we)
            begin
                cfg_reg <= cfg_data;
            end
            if (cmd.scan_start)
            begin
                ctr_reg <= '0;
            end
            else if (cmd.ctr_inc)
            begin
                ctr_reg <= ctr_reg + CW'(1);
            end
            scan_vld_reg <= cmd.rd_en && (cmd.rd_sel == gpst_pkg::SEL_SCAN);
            if (cmd.fin)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.req_load)
        begin
            req_type_reg  <= req_type;
            req_idx_reg   <= slot_index;
            req_id_reg    <= proc_id;
            req_tgt_reg   <= target_handle;
            req_oth_reg   <= other_handle;
            req_exit_reg  <= $unsigned(exit_code);
            req_fvec_reg  <= fault_vector_in;
            req_ferr_reg  <= fault_error_in;
            req_faddr_reg <= fault_address_in;
        end
        if (cmd.rd_en)
        begin
            rd_sel_reg  <= cmd.rd_sel;
            rd_addr_reg <= rd_addr;
        end
        if (cmd.hold_load)
        begin
            hold_reg     <= rd_data;
            hold_idx_reg <= rd_addr_reg;
        end
        if (cmd.place_from_rd)
        begin
            place_idx_reg <= rd_addr_reg;
            place_gen_reg <= rd_data.gen;
        end
        else if (cmd.place_from_free)
        begin
            place_idx_reg <= free_idx_reg;
            place_gen_reg <= free_gen_reg;
        end

        if (cmd.scan_start)
        begin
            dup_reg   <= 1'b0;
            free_reg  <= 1'b0;
            child_reg <= 1'b0;
            found_reg <= 1'b0;
        end
        else if (scan_vld_reg)
        begin
            if (rd_data.state != gpst_pkg::PS_EMPTY && rd_data.id == req_id_reg)
            begin
                dup_reg <= 1'b1;
            end
            if (rd_data.state != gpst_pkg::PS_EMPTY && rd_data.parent == req_tgt_reg)
            begin
                child_reg <= 1'b1;
            end
            if (!free_reg && rd_data.state == gpst_pkg::PS_EMPTY &&
                rd_data.gen != gpst_pkg::GEN_SAT)
            begin
                free_reg     <= 1'b1;
                free_idx_reg <= rd_addr_reg;
                free_gen_reg <= rd_data.gen;
            end
            if (!found_reg && rd_data.state == gpst_pkg::PS_RUN &&
                rd_data.id == req_id_reg)
            begin
                found_reg    <= 1'b1;
                find_idx_reg <= rd_addr_reg;
                find_gen_reg <= rd_data.gen;
            end
        end

        if (cmd.fin)
        begin
            status_reg <= cmd.fin_status;
            if (cmd.fin_status != gpst_pkg::STS_OK)
            begin
                handle_reg <= '0;
                snap_reg   <= '0;
            end
            else
            begin
                unique case (cmd.fin_kind)
                    gpst_pkg::FK_PLACE:
                    begin
                        handle_reg <= {place_gen_inc, 32'(place_idx_reg) + 32'd1};
                        snap_reg   <= '0;
                    end
                    gpst_pkg::FK_FIND:
                    begin
                        handle_reg <= {find_gen_reg, 32'(find_idx_reg) + 32'd1};
                        snap_reg   <= '0;
                    end
                    gpst_pkg::FK_SNAP:
                    begin
                        handle_reg <= {hold_reg.gen, 32'(hold_idx_reg) + 32'd1};
                        snap_reg   <= hold_reg;
                    end
                    default:
                    begin
                        handle_reg <= '0;
                        snap_reg   <= '0;
                    end
                endcase
            end
        end
    end

    assign place_gen_inc = place_gen_reg + 32'd1;

    always_comb
    begin
        unique case (cmd.rd_sel)
            gpst_pkg::SEL_TGT:  rd_addr = AW'(req_tgt_reg[31:0] - 32'd1);
            gpst_pkg::SEL_PAR:  rd_addr = AW'(req_oth_reg[31:0] - 32'd1);
            gpst_pkg::SEL_IDX:  rd_addr = AW'(32'(req_idx_reg));
            default:            rd_addr = ctr_reg[AW-1:0];
        endcase
    end

    always_comb
    begin
        wr_en   = (cmd.wr_op != gpst_pkg::WR_NONE);
        wr_addr = hold_idx_reg;
        wr_data = '0;
        unique case (cmd.wr_op)
            gpst_pkg::WR_CLEAR:
            begin
                wr_addr = ctr_reg[AW-1:0];
            end
            gpst_pkg::WR_PLACE:
            begin
                wr_addr        = place_idx_reg;
                wr_data.state  = gpst_pkg::PS_RUN;
                wr_data.gen    = place_gen_inc;
                wr_data.id     = req_id_reg;
                wr_data.parent = req_oth_reg;
            end
            gpst_pkg::WR_EXIT:
            begin
                wr_data.gen       = hold_reg.gen;
                wr_data.id        = hold_reg.id;
                wr_data.parent    = hold_reg.parent;
                wr_data.state     = gpst_pkg::PS_EXIT;
                wr_data.kind      = gpst_pkg::TK_EXIT;
                wr_data.exit_code = req_exit_reg;
            end
            gpst_pkg::WR_FAULT:
            begin
                wr_data.gen    = hold_reg.gen;
                wr_data.id     = hold_reg.id;
                wr_data.parent = hold_reg.parent;
                wr_data.state  = gpst_pkg::PS_FAULT;
                wr_data.kind   = gpst_pkg::TK_FAULT;
                wr_data.fvec   = req_fvec_reg;
                wr_data.ferr   = req_ferr_reg;
                wr_data.faddr  = req_faddr_reg;
            end
            gpst_pkg::WR_REAP:
            begin
                wr_data.gen = hold_reg.gen;
            end
            default:
            begin
                wr_data = '0;
            end
        endcase
    end

    gpst_ram #(
        .WIDTH (SW),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (cmd.rd_en),
        .raddr (rd_addr),
        .rdata (rd_bits)
    );

    assign rd_data = gpst_pkg::slot_t'(rd_bits);
    assign exp_gen = (rd_sel_reg == gpst_pkg::SEL_PAR) ? req_oth_reg[63:32]
                                                       : req_tgt_reg[63:32];

    always_comb
    begin
        st.req_type     = req_type_reg;
        st.n_zero       = (n == '0);
        st.id_zero      = (req_id_reg == 32'd0);
        st.idx_bad      = (32'(req_idx_reg) >= n32);
        st.tgt_wf       = (req_tgt_reg[63:32] != 32'd0) && (req_tgt_reg[31:0] != 32'd0) &&
                          (req_tgt_reg[31:0] <= n32);
        st.oth_wf       = (req_oth_reg[63:32] != 32'd0) && (req_oth_reg[31:0] != 32'd0) &&
                          (req_oth_reg[31:0] <= n32);
        st.oth_zero     = (req_oth_reg == 64'd0);
        st.rd_live      = (rd_data.state != gpst_pkg::PS_EMPTY) && (rd_data.gen == exp_gen);
        st.rd_state     = rd_data.state;
        st.rd_gen_sat   = (rd_data.gen == gpst_pkg::GEN_SAT);
        st.rd_par_eq    = (rd_data.parent == req_oth_reg);
        st.ctr_at_n     = (ctr_reg == n);
        st.ctr_at_slots = (32'(ctr_reg) == 32'(SLOTS));
        st.scan_pend    = scan_vld_reg;
        st.dup          = dup_reg;
        st.free         = free_reg;
        st.child        = child_reg;
        st.found        = found_reg;
        st.out_free     = !out_vld_reg || !out_stall;
    end

    assign out_valid            = out_vld_reg;
    assign status               = status_reg;
    assign result_handle        = handle_reg;
    assign result_id            = snap_reg.id;
    assign result_parent        = snap_reg.parent;
    assign result_state         = snap_reg.state;
    assign result_kind          = snap_reg.kind;
    assign result_exit_code     = $signed(snap_reg.exit_code);
    assign result_fault_vector  = snap_reg.fvec;
    assign result_fault_error   = snap_reg.ferr;
    assign result_fault_address = snap_reg.faddr;

endmodule
